[rtl/aapc_pkg.sv]
// Shared types and constants for the airbrake apogee PI control core.
// Holds controller states, datapath operations, status bundle and fixed values.
// No dependencies.
package aapc_pkg;

    localparam logic [31:0] RHO0_Q30  = 32'd1315333734;
    localparam logic [31:0] RATIO_Q32 = 32'd4057451438;
    localparam int          STEP_SHIFT = 25;

    localparam logic [2:0] CFG_GRAVITY   = 3'd0;
    localparam logic [2:0] CFG_DRAG_AREA = 3'd1;
    localparam logic [2:0] CFG_MASS      = 3'd2;
    localparam logic [2:0] CFG_TARGET    = 3'd3;
    localparam logic [2:0] CFG_KP        = 3'd4;
    localparam logic [2:0] CFG_KI        = 3'd5;

    localparam logic [23:0] GRAVITY_RST = 24'd642908;
    localparam logic [31:0] MASS_RST    = 32'd65536;
    localparam logic [31:0] KP_RST      = 32'd128849019;
    localparam logic [31:0] KI_RST      = 32'd42950;

    localparam logic signed [31:0] ALT_UNLOCK = 32'sd65536000;
    localparam logic [31:0]        T_UNLOCK   = 32'd262144;
    localparam logic signed [31:0] V_APOGEE   = 32'sd4915200;

    typedef enum logic [4:0] {
        ST_FILL, ST_IDLE, ST_RD_HI, ST_RD_LO, ST_INTERP, ST_RHO, ST_PD,
        ST_KDIV, ST_KWAIT, ST_VSQ, ST_KV0, ST_KV1, ST_KV2, ST_KV3, ST_KV4,
        ST_DEN, ST_HDIV, ST_HWAIT, ST_PRED, ST_CAPDIV, ST_CWAIT, ST_PMUL,
        ST_EMUL, ST_INTEG, ST_IT0, ST_IT1, ST_IT2, ST_DONE
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE, OP_FILL, OP_LOAD, OP_RD_HI, OP_RD_LO, OP_INTERP, OP_RHO,
        OP_PD, OP_KDIV, OP_VSQ, OP_KV0, OP_KV1, OP_KV2, OP_KV3, OP_KV4,
        OP_DEN, OP_HDIV, OP_PRED, OP_CAPDIV, OP_PMUL, OP_EMUL, OP_INTEG,
        OP_IT0, OP_IT1, OP_IT2, OP_RESULT
    } t_op;

    typedef struct packed {
        logic fill_done;
        logic div_busy;
        logic out_busy;
    } t_stat;

endpackage

[rtl/airbrake_apogee_pi_control_core.sv]
// Top level of the airbrake apogee PI control core.
// Joins aapc_ctrl and aapc_dpath; uses aapc_pkg.
//
//   channel   direction  handshake           payload
//   config    in         i_cfg_we            i_cfg_idx, i_cfg_data
//   tick      in         i_valid / o_ready   alt, velocity, accel, time, dt
//   result    out        o_valid / i_ready   deploy, prediction, terms, flags
//
// A tick makes three passes of the shared restoring divider (drag factor,
// climb height, integral cap) plus steps of the shared 32x32 multiplier
// and table reads. After reset the density memory is filled before the
// first transfer is taken. A stalled result holds in the output register
// while the next tick is taken and computed.
module airbrake_apogee_pi_control_core #(
    parameter int DENSITY_TABLE_ENTRIES = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [31:0] i_alt_agl,
    input  logic signed [31:0] i_vel_vertical,
    input  logic signed [31:0] i_accel_x,
    input  logic [31:0]        i_elapsed_time,
    input  logic [16:0]        i_dt,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [16:0]        o_deploy,
    output logic signed [31:0] o_predicted_apogee,
    output logic [31:0]        o_p_term,
    output logic [15:0]        o_i_term,
    output logic               o_control_enabled,
    output logic [3:0]         o_lockout_flags
);
    import aapc_pkg::*;

    t_op   op;
    t_stat stat;

    aapc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (stat),
        .o_op    (op)
    );

    aapc_dpath #(
        .DENSITY_TABLE_ENTRIES (DENSITY_TABLE_ENTRIES)
    ) u_dpath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_op               (op),
        .o_stat             (stat),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .i_alt_agl          (i_alt_agl),
        .i_vel_vertical     (i_vel_vertical),
        .i_accel_x          (i_accel_x),
        .i_elapsed_time     (i_elapsed_time),
        .i_dt               (i_dt),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_deploy           (o_deploy),
        .o_predicted_apogee (o_predicted_apogee),
        .o_p_term           (o_p_term),
        .o_i_term           (o_i_term),
        .o_control_enabled  (o_control_enabled),
        .o_lockout_flags    (o_lockout_flags)
    );
endmodule

[rtl/aapc_div.sv]
// Restoring divider, 64 by 64 bits, one quotient bit per cycle.
// Used by the datapath for the drag factor, climb height and integral cap.
// Depends on nothing.
module aapc_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_dividend,
    input  logic [63:0] i_divisor,
    output logic        o_busy,
    output logic [63:0] o_quot
);
    logic [63:0] r_rem;
    logic [63:0] r_quot;
    logic [63:0] r_dsr;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic [64:0] rem_sh;
    logic        ge;

    assign rem_sh = {r_rem, r_quot[63]};
    assign ge     = rem_sh >= {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 7'd64;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 7'd1;
            if (r_cnt == 7'd1) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_quot <= i_dividend;
            r_dsr  <= i_divisor;
        end else if (r_busy) begin
            r_rem  <= ge ? 64'(rem_sh - {1'b0, r_dsr}) : rem_sh[63:0];
            r_quot <= {r_quot[62:0], ge};
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quot;
endmodule

[rtl/aapc_ctrl.sv]
// Sequencer for the airbrake apogee PI control core.
// Fills the density memory after reset, then steps the datapath through each tick; uses aapc_pkg.
module aapc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  aapc_pkg::t_stat i_stat,
    output aapc_pkg::t_op  o_op
);
    import aapc_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_FILL;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_op    = OP_NONE;
        o_ready = 1'b0;
        case (r_state)
            ST_FILL: begin
                if (i_stat.fill_done) begin
                    n_state = ST_IDLE;
                end else begin
                    o_op = OP_FILL;
                end
            end
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_op    = OP_LOAD;
                    n_state = ST_RD_HI;
                end
            end
            ST_RD_HI:  begin o_op = OP_RD_HI;  n_state = ST_RD_LO;  end
            ST_RD_LO:  begin o_op = OP_RD_LO;  n_state = ST_INTERP; end
            ST_INTERP: begin o_op = OP_INTERP; n_state = ST_RHO;    end
            ST_RHO:    begin o_op = OP_RHO;    n_state = ST_PD;     end
            ST_PD:     begin o_op = OP_PD;     n_state = ST_KDIV;   end
            ST_KDIV:   begin o_op = OP_KDIV;   n_state = ST_KWAIT;  end
            ST_KWAIT: begin
                if (!i_stat.div_busy) begin
                    n_state = ST_VSQ;
                end
            end
            ST_VSQ:    begin o_op = OP_VSQ;    n_state = ST_KV0;    end
            ST_KV0:    begin o_op = OP_KV0;    n_state = ST_KV1;    end
            ST_KV1:    begin o_op = OP_KV1;    n_state = ST_KV2;    end
            ST_KV2:    begin o_op = OP_KV2;    n_state = ST_KV3;    end
            ST_KV3:    begin o_op = OP_KV3;    n_state = ST_KV4;    end
            ST_KV4:    begin o_op = OP_KV4;    n_state = ST_DEN;    end
            ST_DEN:    begin o_op = OP_DEN;    n_state = ST_HDIV;   end
            ST_HDIV:   begin o_op = OP_HDIV;   n_state = ST_HWAIT;  end
            ST_HWAIT: begin
                if (!i_stat.div_busy) begin
                    n_state = ST_PRED;
                end
            end
            ST_PRED:   begin o_op = OP_PRED;   n_state = ST_CAPDIV; end
            ST_CAPDIV: begin o_op = OP_CAPDIV; n_state = ST_CWAIT;  end
            ST_CWAIT: begin
                if (!i_stat.div_busy) begin
                    n_state = ST_PMUL;
                end
            end
            ST_PMUL:   begin o_op = OP_PMUL;   n_state = ST_EMUL;   end
            ST_EMUL:   begin o_op = OP_EMUL;   n_state = ST_INTEG;  end
            ST_INTEG:  begin o_op = OP_INTEG;  n_state = ST_IT0;    end
            ST_IT0:    begin o_op = OP_IT0;    n_state = ST_IT1;    end
            ST_IT1:    begin o_op = OP_IT1;    n_state = ST_IT2;    end
            ST_IT2:    begin o_op = OP_IT2;    n_state = ST_DONE;   end
            ST_DONE: begin
                if (!i_stat.out_busy) begin
                    o_op    = OP_RESULT;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end
endmodule

[rtl/aapc_dpath.sv]
// Datapath: configuration, lockouts, density memory, shared multiplier,
// divider and output register. Uses aapc_pkg and aapc_div.
module aapc_dpath #(
    parameter int DENSITY_TABLE_ENTRIES = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  aapc_pkg::t_op       i_op,
    output aapc_pkg::t_stat     o_stat,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_idx,
    input  logic [31:0]         i_cfg_data,
    input  logic signed [31:0]  i_alt_agl,
    input  logic signed [31:0]  i_vel_vertical,
    input  logic signed [31:0]  i_accel_x,
    input  logic [31:0]         i_elapsed_time,
    input  logic [16:0]         i_dt,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [16:0]         o_deploy,
    output logic signed [31:0]  o_predicted_apogee,
    output logic [31:0]         o_p_term,
    output logic [15:0]         o_i_term,
    output logic                o_control_enabled,
    output logic [3:0]          o_lockout_flags
);
    import aapc_pkg::*;

    localparam int AW = $clog2(DENSITY_TABLE_ENTRIES);
    localparam int LAST = DENSITY_TABLE_ENTRIES - 1;

    logic [31:0] mem [DENSITY_TABLE_ENTRIES];

    logic [23:0] r_gravity;
    logic [31:0] r_drag;
    logic [31:0] r_mass;
    logic [30:0] r_target;
    logic [31:0] r_kp;
    logic [31:0] r_ki;
    logic [3:0]  r_lock;
    logic        r_en;
    logic [47:0] r_integ;
    logic [AW:0] r_fill_cnt;
    logic [31:0] r_fill_val;
    logic        r_out_valid;

    logic signed [31:0] r_alt;
    logic signed [31:0] r_vel;
    logic [16:0]  r_dt;
    logic [31:0]  r_rd;
    logic [31:0]  r_hiv;
    logic [31:0]  r_rho;
    logic [63:0]  r_prod;
    logic [63:0]  r_k;
    logic [63:0]  r_vsq;
    logic [127:0] r_acc;
    logic [63:0]  r_den;
    logic [31:0]  r_pred;
    logic [31:0]  r_err;
    logic [47:0]  r_cap;
    logic [31:0]  r_pterm;
    logic [31:0]  r_ilo;
    logic [15:0]  r_iterm;

    logic [3:0]   n_lock;
    logic         n_en;
    logic [30:0]  alt_pos;
    logic [5:0]   idx;
    logic         at_last;
    logic [AW-1:0] addr_hi;
    logic [AW-1:0] addr_lo;
    logic [AW-1:0] rd_addr;
    logic [31:0]  mul_a;
    logic [31:0]  mul_b;
    logic [63:0]  fill_prod;
    logic         div_start;
    logic [63:0]  div_dvd;
    logic [63:0]  div_dsr;
    logic         div_busy;
    logic [63:0]  div_q;
    logic [69:0]  kv_raw;
    logic [62:0]  kv;
    logic [32:0]  h;
    logic [33:0]  pred_sum;
    logic [31:0]  pred;
    logic [32:0]  diff;
    logic         err_pos;
    logic [48:0]  integ_sum;
    logic [47:0]  integ_next;
    logic [32:0]  dep_sum;

    always_comb begin
        n_lock[0] = r_lock[0] & ~i_accel_x[31];
        n_lock[1] = r_lock[1] & ~(i_alt_agl > ALT_UNLOCK);
        n_lock[2] = r_lock[2] & ~(i_elapsed_time > T_UNLOCK);
        n_lock[3] = r_lock[3] | (r_en & (i_vel_vertical < V_APOGEE));
        n_en      = ~|n_lock;
    end

    assign alt_pos = r_alt[31] ? 31'd0 : r_alt[30:0];
    assign idx     = alt_pos[30:STEP_SHIFT];
    assign at_last = 32'(idx) >= LAST;
    assign addr_hi = at_last ? AW'(LAST) : AW'(idx);
    assign addr_lo = at_last ? AW'(LAST) : AW'(32'(idx) + 1);
    assign rd_addr = (i_op == OP_RD_LO) ? addr_lo : addr_hi;

    assign fill_prod = r_fill_val * RATIO_Q32;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_op)
            OP_INTERP: begin
                mul_a = r_hiv - r_rd;
                mul_b = {7'd0, alt_pos[STEP_SHIFT-1:0]};
            end
            OP_PD:   begin mul_a = r_rho;          mul_b = r_drag;          end
            OP_VSQ:  begin mul_a = r_vel;          mul_b = r_vel;           end
            OP_KV0:  begin mul_a = r_k[31:0];      mul_b = r_prod[31:0];    end
            OP_KV1:  begin mul_a = r_k[31:0];      mul_b = r_vsq[63:32];    end
            OP_KV2:  begin mul_a = r_k[63:32];     mul_b = r_vsq[31:0];     end
            OP_KV3:  begin mul_a = r_k[63:32];     mul_b = r_vsq[63:32];    end
            OP_PMUL: begin mul_a = r_kp;           mul_b = r_err;           end
            OP_EMUL: begin mul_a = r_err;          mul_b = {15'd0, r_dt};   end
            OP_IT0:  begin mul_a = r_ki;           mul_b = r_integ[31:0];   end
            OP_IT1:  begin mul_a = r_ki;           mul_b = {16'd0, r_integ[47:32]}; end
            default: begin mul_a = '0;             mul_b = '0;              end
        endcase
    end

    always_comb begin
        div_start = 1'b0;
        div_dvd   = '0;
        div_dsr   = '0;
        case (i_op)
            OP_KDIV: begin
                div_start = 1'b1;
                div_dvd   = r_prod;
                div_dsr   = (r_mass == 32'd0) ? 64'd1 : {32'd0, r_mass};
            end
            OP_HDIV: begin
                div_start = 1'b1;
                div_dvd   = r_vsq;
                div_dsr   = r_den;
            end
            OP_CAPDIV: begin
                div_start = 1'b1;
                div_dvd   = 64'h0000_8000_0000_0000;
                div_dsr   = {32'd0, r_ki};
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    aapc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dsr),
        .o_busy     (div_busy),
        .o_quot     (div_q)
    );

    assign kv_raw = r_acc[127:58];
    assign kv     = (kv_raw > (70'd1 << 62)) ? (63'd1 << 62) : kv_raw[62:0];

    assign h        = (div_q > 64'h1_0000_0000) ? 33'h1_0000_0000 : div_q[32:0];
    assign pred_sum = {{2{r_alt[31]}}, r_alt} + {1'b0, h};
    assign pred     = ($signed(pred_sum) > 34'sd2147483647) ? 32'h7FFF_FFFF
                                                           : pred_sum[31:0];

    assign diff    = {r_pred[31], r_pred} - {2'b00, r_target};
    assign err_pos = r_en & ~diff[32] & (diff != 33'd0);

    assign integ_sum  = {1'b0, r_integ} + {16'd0, r_prod[48:16]};
    assign integ_next = (r_err == 32'd0) ? 48'd0 :
                        (integ_sum > {1'b0, r_cap}) ? r_cap : integ_sum[47:0];

    assign dep_sum = {1'b0, r_pterm} + {17'd0, r_iterm};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gravity   <= GRAVITY_RST;
            r_drag      <= '0;
            r_mass      <= MASS_RST;
            r_target    <= '0;
            r_kp        <= KP_RST;
            r_ki        <= KI_RST;
            r_lock      <= 4'b0111;
            r_en        <= 1'b0;
            r_integ     <= '0;
            r_fill_cnt  <= '0;
            r_fill_val  <= RHO0_Q30;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_GRAVITY:   r_gravity <= i_cfg_data[23:0];
                    CFG_DRAG_AREA: r_drag    <= i_cfg_data;
                    CFG_MASS:      r_mass    <= i_cfg_data;
                    CFG_TARGET:    r_target  <= i_cfg_data[30:0];
                    CFG_KP:        r_kp      <= i_cfg_data;
                    CFG_KI:        r_ki      <= i_cfg_data;
                    default:       r_kp      <= r_kp;
                endcase
            end
            if (i_op == OP_RESULT) begin
                r_out_valid <= 1'b1;
            end else if (o_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (i_op)
                OP_FILL: begin
                    r_fill_cnt <= r_fill_cnt + 1'b1;
                    r_fill_val <= fill_prod[63:32];
                end
                OP_LOAD: begin
                    r_lock <= n_lock;
                    r_en   <= n_en;
                end
                OP_INTEG:  r_integ     <= integ_next;
                default:   r_en        <= r_en;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_op == OP_FILL) begin
            mem[r_fill_cnt[AW-1:0]] <= r_fill_val;
        end
        r_rd <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        case (i_op)
            OP_LOAD: begin
                r_alt <= i_alt_agl;
                r_vel <= i_vel_vertical;
                r_dt  <= i_dt;
            end
            OP_RD_LO:  r_hiv  <= r_rd;
            OP_INTERP: r_prod <= mul_a * mul_b;
            OP_RHO:    r_rho  <= r_hiv - r_prod[56:25];
            OP_PD:     r_prod <= mul_a * mul_b;
            OP_VSQ: begin
                r_k    <= div_q;
                r_prod <= mul_a * mul_b;
            end
            OP_KV0: begin
                r_vsq  <= r_prod;
                r_acc  <= '0;
                r_prod <= mul_a * mul_b;
            end
            OP_KV1: begin
                r_acc  <= r_acc + {64'd0, r_prod};
                r_prod <= mul_a * mul_b;
            end
            OP_KV2: begin
                r_acc  <= r_acc + {32'd0, r_prod, 32'd0};
                r_prod <= mul_a * mul_b;
            end
            OP_KV3: begin
                r_acc  <= r_acc + {32'd0, r_prod, 32'd0};
                r_prod <= mul_a * mul_b;
            end
            OP_KV4:    r_acc <= r_acc + {r_prod, 64'd0};
            OP_DEN:    r_den <= {39'd0, r_gravity, 1'b0} + {1'b0, kv};
            OP_PRED:   r_pred <= (r_vel[31] || r_vel == 32'sd0) ? r_alt : pred;
            OP_CAPDIV: r_err <= err_pos ? diff[31:0] : 32'd0;
            OP_PMUL: begin
                r_cap  <= (r_ki == 32'd0) ? 48'hFFFF_FFFF_FFFF : div_q[47:0];
                r_prod <= mul_a * mul_b;
            end
            OP_EMUL: begin
                r_pterm <= r_prod[63:32];
                r_prod  <= mul_a * mul_b;
            end
            OP_IT0:    r_prod <= mul_a * mul_b;
            OP_IT1: begin
                r_ilo  <= r_prod[63:32];
                r_prod <= mul_a * mul_b;
            end
            OP_IT2:    r_iterm <= 16'(r_ilo + r_prod[31:0]);
            OP_RESULT: begin
                o_deploy           <= (dep_sum > 33'd65536) ? 17'h10000 : dep_sum[16:0];
                o_predicted_apogee <= r_pred;
                o_p_term           <= r_pterm;
                o_i_term           <= r_iterm;
                o_control_enabled  <= r_en;
                o_lockout_flags    <= r_lock;
            end
            default: r_hiv <= r_hiv;
        endcase
    end

    assign o_valid          = r_out_valid;
    assign o_stat.fill_done = (r_fill_cnt == (AW+1)'(DENSITY_TABLE_ENTRIES));
    assign o_stat.div_busy  = div_busy;
    assign o_stat.out_busy  = r_out_valid & ~i_ready;
endmodule
